FILE: hw/rtl/u2a_pkg.sv
package u2a_pkg;

  // eleven digit slots cover octal of the largest 32-bit value
  localparam int unsigned NumDigits = 11;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned StepWidth = $clog2(ValueWidth);
  localparam int unsigned PosWidth = $clog2(NumDigits);

  localparam logic [6:0] AsciiZero = 7'd48;
  localparam logic [6:0] LowerOffset = 7'd87;
  localparam logic [6:0] UpperOffset = 7'd55;

  typedef logic [3:0] digit_t;
  typedef digit_t [NumDigits-1:0] digits_t;

  typedef enum logic [1:0] {
    OP_DEC    = 2'd0,
    OP_OCT    = 2'd1,
    OP_HEX_LO = 2'd2,
    OP_HEX_UP = 2'd3
  } op_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } char_item_t;

  function automatic logic [6:0] ascii_of(input digit_t digit, input op_t op);
    logic [6:0] d;
    d = {3'b000, digit};
    if (digit <= 4'd9) begin
      return d + AsciiZero;
    end else if (op == OP_HEX_UP) begin
      return d + UpperOffset;
    end else begin
      return d + LowerOffset;
    end
  endfunction

endpackage

FILE: hw/rtl/u2a_dabble_step.sv
// one shift-and-add-3 step of binary to bcd conversion
module u2a_dabble_step (
  input  u2a_pkg::digits_t                   digits,
  input  logic [u2a_pkg::ValueWidth-1:0]     bin,
  output u2a_pkg::digits_t                   digits_next,
  output logic [u2a_pkg::ValueWidth-1:0]     bin_next
);

  u2a_pkg::digits_t adj;
  logic [4*u2a_pkg::NumDigits-1:0] adj_bits;

  always_comb begin
    for (int i = 0; i < u2a_pkg::NumDigits; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
    adj_bits    = adj;
    digits_next = {adj_bits[4*u2a_pkg::NumDigits-2:0], bin[u2a_pkg::ValueWidth-1]};
    bin_next    = {bin[u2a_pkg::ValueWidth-2:0], 1'b0};
  end

endmodule

FILE: hw/rtl/u2a_out_reg.sv
// single output register holding one character item
module u2a_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  u2a_pkg::char_item_t push_item,
  output logic                ready,
  output logic                digit_valid,
  input  logic                digit_stall,
  output logic [6:0]          character,
  output logic                last
);

  u2a_pkg::char_item_t item;

  assign ready       = !digit_valid || !digit_stall;
  assign character   = item.character;
  assign last        = item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (ready) begin
      digit_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      item <= push_item;
    end
  end

endmodule

FILE: hw/rtl/unsigned_to_ascii_digits_core.sv
// sequence: a decimal item goes through the conversion, the scan and then the output register;
// octal and hex items skip the conversion
// the next item is taken only once its last digit has been pushed and the sequencer is back
// in idle; sink stalls hold up the digits and so delay the next item
// reset: rst is synchronous active high, returns the sequencer to idle and empties
// the output register
module unsigned_to_ascii_digits_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        num_valid,
  output logic        num_stall,
  input  logic [31:0] value,
  input  logic [1:0]  operation,
  output logic        digit_valid,
  input  logic        digit_stall,
  output logic [6:0]  character,
  output logic        last
);

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;

  // digit slots, most significant in the top slot
  u2a_pkg::digits_t                   digits;
  logic [u2a_pkg::ValueWidth-1:0]     bin;
  // conversion step count, one input bit per cycle
  logic [u2a_pkg::StepWidth-1:0]      step;
  // slot of the next digit to send
  logic [u2a_pkg::PosWidth-1:0]       pos;
  u2a_pkg::op_t                       op;

  u2a_pkg::digits_t                   dd_digits_next;
  logic [u2a_pkg::ValueWidth-1:0]     dd_bin_next;
  u2a_pkg::digits_t                   load_digits;
  logic [u2a_pkg::PosWidth-1:0]       msd;
  logic [4*u2a_pkg::NumDigits-1:0]    value_ext;

  logic                accept;
  logic                out_ready;
  logic                push;
  u2a_pkg::char_item_t push_item;

  assign num_stall = (state != ST_IDLE);
  assign accept    = num_valid && !num_stall;

  // shared shift-and-add-3 unit for decimal
  u2a_dabble_step u_step (
    .digits      (digits),
    .bin         (bin),
    .digits_next (dd_digits_next),
    .bin_next    (dd_bin_next)
  );

  // octal and hex digits are plain bit slices of the value
  always_comb begin
    value_ext = {{(4*u2a_pkg::NumDigits-u2a_pkg::ValueWidth){1'b0}}, value};
    for (int i = 0; i < u2a_pkg::NumDigits; i++) begin
      if (u2a_pkg::op_t'(operation) == u2a_pkg::OP_OCT) begin
        load_digits[i] = {1'b0, value_ext[3*i +: 3]};
      end else begin
        load_digits[i] = value_ext[4*i +: 4];
      end
    end
  end

  // highest nonzero slot; zero value leaves the bottom slot
  always_comb begin
    msd = '0;
    for (int i = 0; i < u2a_pkg::NumDigits; i++) begin
      if (digits[i] != 4'd0) begin
        msd = u2a_pkg::PosWidth'(i);
      end
    end
  end

  // next character for the output register
  assign push              = (state == ST_EMIT) && out_ready;
  assign push_item.character = u2a_pkg::ascii_of(digits[pos], op);
  assign push_item.last    = (pos == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (u2a_pkg::op_t'(operation) == u2a_pkg::OP_DEC) ? ST_CONV : ST_SCAN;
          end
        end
        ST_CONV: begin
          if (step == '1) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (push && push_item.last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op   <= u2a_pkg::op_t'(operation);
          bin  <= value;
          step <= '0;
          if (u2a_pkg::op_t'(operation) == u2a_pkg::OP_DEC) begin
            digits <= '0;
          end else begin
            digits <= load_digits;
          end
        end
      end
      ST_CONV: begin
        digits <= dd_digits_next;
        bin    <= dd_bin_next;
        step   <= step + 1'b1;
      end
      ST_SCAN: begin
        pos <= msd;
      end
      ST_EMIT: begin
        if (push && !push_item.last) begin
          pos <= pos - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  u2a_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_item   (push_item),
    .ready       (out_ready),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .character   (character),
    .last        (last)
  );

endmodule

FILE: hw/rtl/u2a_checker.sv
module u2a_checker (
  input logic       clk,
  input logic       rst,
  input logic       num_valid,
  input logic       num_stall,
  input logic       digit_valid,
  input logic       digit_stall,
  input logic [6:0] character,
  input logic       last
);

  // a stalled character holds
  assert property (@(posedge clk) disable iff (rst)
    digit_valid && digit_stall |=> digit_valid && $stable(character) && $stable(last))
    else $error("stalled character changed");

  // one item at a time: input closes right after an accept
  assert property (@(posedge clk) disable iff (rst)
    num_valid && !num_stall |=> num_stall)
    else $error("input not stalled after accept");

  // input reopens only as the final digit of the item appears
  assert property (@(posedge clk) disable iff (rst)
    $fell(num_stall) |-> digit_valid && last)
    else $error("input reopened before final digit");

  // only digit characters appear
  assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> (character >= 7'd48 && character <= 7'd57) ||
                    (character >= 7'd97 && character <= 7'd102) ||
                    (character >= 7'd65 && character <= 7'd70))
    else $error("character outside digit set");

endmodule

bind unsigned_to_ascii_digits_core u2a_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .num_valid   (num_valid),
  .num_stall   (num_stall),
  .digit_valid (digit_valid),
  .digit_stall (digit_stall),
  .character   (character),
  .last        (last)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // radix of each operation
  localparam int unsigned RadixDec = 10;
  localparam int unsigned RadixOct = 8;
  localparam int unsigned RadixHex = 16;

  // cycles the block may still be busy after its last digit, and the watchdog limit
  localparam int DrainCycles = 60;
  localparam int IdleLimit = 3000;
  // long receiver hold-off used to back the block up into its input
  localparam int HoldCycles = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        num_valid = 1'b0;
  logic        num_stall;
  logic [31:0] value = '0;
  logic [1:0]  operation = u2a_pkg::OP_DEC;
  logic        digit_valid;
  logic        digit_stall = 1'b0;
  logic [6:0]  character;
  logic        last;

  // characters still owed by the block, oldest first
  u2a_pkg::char_item_t expected_chars[$];
  int         errors = 0;

  // knobs shared by the test tasks and the two traffic processes
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold = 0;
  int idle_cycles = 0;

  unsigned_to_ascii_digits_core u_top (
    .clk         (clk),
    .rst         (rst),
    .num_valid   (num_valid),
    .num_stall   (num_stall),
    .value       (value),
    .operation   (operation),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .character   (character),
    .last        (last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // expected digit string of one number, pushed most significant first
  function automatic void expand_digits(input logic [31:0] num, input u2a_pkg::op_t op);
    logic [3:0]  digs [11];
    int          count;
    int unsigned radix;
    logic [31:0] rest;
    logic [6:0]  code;
    u2a_pkg::char_item_t item;
    case (op)
      u2a_pkg::OP_DEC: radix = RadixDec;
      u2a_pkg::OP_OCT: radix = RadixOct;
      default:         radix = RadixHex;
    endcase
    rest = num;
    count = 0;
    // peel off digits, least significant first
    do begin
      digs[count] = 4'(rest % radix);
      rest = rest / radix;
      count++;
    end while (rest != 0);
    for (int k = count - 1; k >= 0; k--) begin
      code = {3'b000, digs[k]};
      // nine stays a numeral even in hex
      if (digs[k] <= 4'd9) begin
        item.character = code + u2a_pkg::AsciiZero;
      end else if (op == u2a_pkg::OP_HEX_UP) begin
        item.character = code + u2a_pkg::UpperOffset;
      end else begin
        item.character = code + u2a_pkg::LowerOffset;
      end
      item.last = (k == 0);
      expected_chars.push_back(item);
    end
  endfunction

  // random number shaped to spread the digit count over its whole range
  function automatic logic [31:0] pick_value(input u2a_pkg::op_t op);
    logic [31:0] p;
    int unsigned radix;
    int          steps;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 40);
      2: begin
        // near a power of the radix, where the digit count steps up
        radix = (op == u2a_pkg::OP_DEC) ? RadixDec :
                (op == u2a_pkg::OP_OCT) ? RadixOct : RadixHex;
        steps = $urandom_range(1, 10);
        p = 32'd1;
        for (int k = 0; k < steps; k++) begin
          p = p * radix;
        end
        return p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // offer one item, hold it until taken, then maybe leave a gap
  task automatic send_item(input logic [31:0] num, input u2a_pkg::op_t op);
    int gap;
    num_valid <= 1'b1;
    value     <= num;
    operation <= op;
    do @(posedge clk); while (!(num_valid && !num_stall));
    expand_digits(num, op);
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      num_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every owed character has come, then let the block settle
  task automatic wait_drained();
    num_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // extremes of each radix, zero, hex nine, letters in both cases
  task automatic test_corner_values();
    u2a_pkg::op_t ops [4] = '{u2a_pkg::OP_DEC, u2a_pkg::OP_OCT,
                              u2a_pkg::OP_HEX_LO, u2a_pkg::OP_HEX_UP};
    foreach (ops[i]) begin
      send_item(32'd0, ops[i]);
      send_item(32'hFFFF_FFFF, ops[i]);
    end
    send_item(32'd9, u2a_pkg::OP_HEX_LO);
    send_item(32'h9999_9999, u2a_pkg::OP_HEX_UP);
    send_item(32'h89AB_CDEF, u2a_pkg::OP_HEX_LO);
    send_item(32'hFEDC_BA98, u2a_pkg::OP_HEX_UP);
    send_item(32'h0000_000A, u2a_pkg::OP_HEX_UP);
    send_item(32'd1, u2a_pkg::OP_DEC);
    send_item(32'd10, u2a_pkg::OP_DEC);
    send_item(32'd999_999_999, u2a_pkg::OP_DEC);
    send_item(32'd1_000_000_000, u2a_pkg::OP_DEC);
    send_item(32'd7, u2a_pkg::OP_OCT);
    send_item(32'd8, u2a_pkg::OP_OCT);
    send_item(32'h4000_0000, u2a_pkg::OP_OCT);
    send_item(32'h3FFF_FFFF, u2a_pkg::OP_OCT);
    send_item(32'h1000_0000, u2a_pkg::OP_HEX_LO);
    send_item(32'h8000_0000, u2a_pkg::OP_DEC);
    send_item(32'h5555_5555, u2a_pkg::OP_DEC);
  endtask

  // random mix with idling on both sides
  task automatic test_random_mix(input int count);
    u2a_pkg::op_t op;
    for (int i = 0; i < count; i++) begin
      op = u2a_pkg::op_t'($urandom_range(0, 3));
      send_item(pick_value(op), op);
    end
  endtask

  // no gaps on either side for a stretch
  task automatic test_back_to_back(input int count);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    test_random_mix(count);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // receiver holds off while the sender keeps pushing, so the input backs up
  task automatic test_receiver_hold(input int count);
    tx_calm = 1'b1;
    rx_hold = HoldCycles;
    test_random_mix(count);
    tx_calm = 1'b0;
  endtask

  // sender pauses until the block has emptied, then resumes
  task automatic test_drain_pause(input int count);
    test_random_mix(count);
    wait_drained();
    test_random_mix(count);
  endtask

  // receiver: random stalls, or a long hold when a test asks for one
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        stall_left = rx_hold;
        rx_hold = 0;
      end
      if (stall_left > 0) begin
        digit_stall <= 1'b1;
        stall_left--;
      end else begin
        digit_stall <= 1'b0;
        if (!rx_calm && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // compare each accepted character against the oldest one owed
  always @(posedge clk) begin : check_chars
    u2a_pkg::char_item_t want;
    if (!rst && digit_valid && !digit_stall) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character expected none actual %h last %b",
                 $time, character, last);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (character !== want.character) begin
          $display("%0t: character mismatch expected %h actual %h",
                   $time, want.character, character);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: last mismatch expected %b actual %b", $time, want.last, last);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without any handshake on either side means a hang
  always @(posedge clk) begin
    if (rst || (num_valid && !num_stall) || (digit_valid && !digit_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[unsigned_to_ascii_digits_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // reset held high from the start, then released at an edge
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_corner_values();
    test_back_to_back(60);
    test_receiver_hold(40);
    test_drain_pause(20);
    test_random_mix(330);
    wait_drained();
    if (errors == 0) begin
      $display("[unsigned_to_ascii_digits_core] OK");
    end else begin
      $display("[unsigned_to_ascii_digits_core] ERROR");
    end
    $finish;
  end

endmodule
